### rtl/core/stable_priority_queue_defines.svh
// Assertion macros shared by the stable priority queue RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent is followed in the next cycle by a consequent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/spq_pkg.sv
// Types and codes of the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
`timescale 1ns / 1ps

package spq_pkg;

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  pri;
		logic [9:0]  mem;
		logic [8:0]  run_time;
	} rec_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] proc_id;
		logic [2:0]  proc_priority;
		logic [9:0]  proc_memory;
		logic [8:0]  proc_time;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_id;
		logic [2:0]  out_priority;
		logic [9:0]  out_memory;
		logic [8:0]  out_time;
		logic        now_empty;
		logic [4:0]  held_count;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
		rec_t new_rec;
	} spq_cmd_t;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted chain: keeps its record, loads the new record, or takes its left or right neighbor's record.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
	input  logic             clk,
	input  spq_pkg::spq_cmd_t cmd,
	input  logic             occupied,
	input  logic             left_keep,
	input  spq_pkg::rec_t    left_rec,
	input  spq_pkg::rec_t    right_rec,
	output spq_pkg::rec_t    rec,
	output logic             keep
);
	import spq_pkg::*;

	rec_t rec_q;

	// A held record stays put when its priority does not exceed the new one.
	assign keep = occupied && (rec_q.pri <= cmd.new_rec.pri);
	assign rec  = rec_q;

	always_ff @(posedge clk) begin
		priority if (cmd.enq && !keep && left_keep) begin
			rec_q <= cmd.new_rec;
		end else if (cmd.enq && !keep) begin
			rec_q <= left_rec;
		end else if (cmd.deq) begin
			rec_q <= right_rec;
		end
	end

endmodule

### rtl/core/stable_priority_queue.sv
// A result appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; every cell of the chain moves in parallel.
// A result waiting under stall blocks new requests until it is taken.
// Reset clears the record count and the result valid; record slots are not cleared.
// Depends on spq_pkg, spq_cell and stable_priority_queue_defines.svh.
`timescale 1ns / 1ps

module stable_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	`include "stable_priority_queue_defines.svh"

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// The queue is a row of cells in service order; cell 0 holds the front record.
	// Only cells below count_q are occupied, so no per-slot valid bits exist.
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	rec_t     cell_rec [QUEUE_DEPTH];
	logic     cell_keep [QUEUE_DEPTH];
	spq_cmd_t cmd;

	logic          accept;
	logic          full;
	logic          empty;
	logic [CW-1:0] count_next;
	logic [CW+4:0] count_ext;
	rsp_t          rsp_next;

	// A new request is taken whenever the result register is free or being drained.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		cmd.enq              = accept && (req.kind == KIND_ENQ) && !full;
		cmd.deq              = accept && (req.kind == KIND_DEQ) && !empty;
		cmd.new_rec.id       = req.proc_id;
		cmd.new_rec.pri      = req.proc_priority;
		cmd.new_rec.mem      = req.proc_memory;
		cmd.new_rec.run_time = req.proc_time;
	end

	// Each cell either keeps its record, takes the new one (when it does not keep
	// but its left neighbor does), takes its left neighbor's record on an
	// insert, or takes its right neighbor's record on a removal.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic occ;
		logic lkeep;
		rec_t lrec;
		rec_t rrec;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign lkeep = 1'b1;
			assign lrec  = cmd.new_rec;
		end else begin : g_inner
			assign lkeep = cell_keep[i-1];
			assign lrec  = cell_rec[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rrec = cell_rec[i];
		end else begin : g_mid
			assign rrec = cell_rec[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occupied  (occ),
			.left_keep (lkeep),
			.left_rec  (lrec),
			.right_rec (rrec),
			.rec       (cell_rec[i]),
			.keep      (cell_keep[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (cmd.enq) begin
			count_next = count_q + CW'(1);
		end else if (cmd.deq) begin
			count_next = count_q - CW'(1);
		end
	end

	// Held count is reported modulo 32 when the depth exceeds 31.
	assign count_ext = {5'd0, count_next};

	always_comb begin
		rsp_next              = '0;
		rsp_next.status       = ST_DONE;
		rsp_next.now_empty    = (count_next == '0);
		rsp_next.held_count   = count_ext[4:0];
		if (req.kind == KIND_ENQ) begin
			if (full) begin
				rsp_next.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_next.status = ST_EMPTY;
		end else begin
			rsp_next.out_id       = cell_rec[0].id;
			rsp_next.out_priority = cell_rec[0].pri;
			rsp_next.out_memory   = cell_rec[0].mem;
			rsp_next.out_time     = cell_rec[0].run_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CW'(QUEUE_DEPTH), "record count exceeds depth")
	`SPQ_ASSERT_NEXT(a_enq_grows, cmd.enq, count_q == $past(count_q) + CW'(1), "insert lost")
	`SPQ_ASSERT_NEXT(a_deq_shrinks, cmd.deq, count_q == $past(count_q) - CW'(1), "remove lost")
	`SPQ_ASSERT_NEXT(a_result_follows, accept, rsp_valid_q, "accepted request gave no result")
	`SPQ_ASSERT(a_empty_matches, !rsp_valid_q || (rsp_q.now_empty == (count_q == '0)),
		"result empty flag disagrees with count")

endmodule
